// File: hdl/mfss_pkg.sv
// shared types, constants and the sequencer program of the major frame slot scheduler
package mfss_pkg;

   localparam int TIME_W       = 63;
   localparam int RUNTIME_W    = 40;
   localparam int SLOT_W       = 7;
   localparam int INDEX_W      = 6;
   localparam int REQ_DATA_W   = 112;
   localparam int RSP_DATA_W   = 72;
   localparam int CSR_INDEX_W  = 8;
   localparam int CSR_DATA_W   = 40;
   localparam int PC_W         = 4;
   localparam int PROG_LEN     = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAJOR_FRAME_LENGTH = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT        = 8'd1;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_DECIDE = 1'b1;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_RESTART,
      OP_LOAD_FIRST,
      OP_ADVANCE,
      OP_ADD,
      OP_POST,
      OP_EMPTY,
      OP_RESULT
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_EMPTY,
      C_BEFORE_FRAME,
      C_WALK_DONE,
      C_LAST_SLOT,
      C_DUE_AGAIN
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic before_frame;
      logic walk_done;
      logic last_slot;
      logic due_again;
      logic stall;
   } flags_type;

   localparam pc_type L_WAIT   = 4'd0;
   localparam pc_type L_WALK   = 4'd5;
   localparam pc_type L_STEP   = 4'd6;
   localparam pc_type L_POST   = 4'd8;
   localparam pc_type L_EMPTY  = 4'd10;

   localparam ctrl_type PROGRAM [PROG_LEN] = '{
      '{OP_WAIT,       C_NEVER,        L_WAIT},
      '{OP_NOP,        C_EMPTY,        L_EMPTY},
      '{OP_NOP,        C_BEFORE_FRAME, L_WALK},
      '{OP_RESTART,    C_NEVER,        L_WAIT},
      '{OP_LOAD_FIRST, C_ALWAYS,       L_POST},
      '{OP_NOP,        C_WALK_DONE,    L_POST},
      '{OP_ADVANCE,    C_LAST_SLOT,    L_POST},
      '{OP_ADD,        C_DUE_AGAIN,    L_STEP},
      '{OP_POST,       C_NEVER,        L_WAIT},
      '{OP_RESULT,     C_ALWAYS,       L_WAIT},
      '{OP_EMPTY,      C_ALWAYS,       L_POST}
   };

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
   endfunction

endpackage

// File: hdl/major_frame_slot_scheduler.sv
// top level of the major frame slot scheduler
// Table-driven time-partition scheduler. A request beat with tuser 0 writes one slot runtime
// and gives no response; with tuser 1 it asks for a decision at the given time and gives one
// response beat: the active slot, an idle flag and the time until the next decision. With an
// empty table a decision takes the default slice; at or after the frame end it restarts the
// frame and loads the first slot; else it walks past each expired slot in a two-step loop
// (advance, then add) set by the registered read port of the runtime memory, stopping at the
// last slot. The sequencer then returns to its wait step, ready for the next beat, and a
// response still held by a low rsp_tready stalls the result step until it leaves. A write beat
// is taken in the wait step. Configuration writes (0: major frame length, 1: entry count) are
// taken whenever offered and belong to idle periods only.
module major_frame_slot_scheduler
   import mfss_pkg::*;
#(
   parameter int MAX_SLOTS        = 64,
   parameter int DEFAULT_SLICE_NS = 10000000
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // slot_index, slot_runtime, current_time, tasklet_pending, zero pad
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // mode
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // chosen_slot, slice_length, zero pad
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // is_idle
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   ctrl_type             ctrl;
   flags_type            flags;
   logic                 tbl_wr_en;
   logic [AW-1:0]        tbl_wr_addr;
   logic [RUNTIME_W-1:0] tbl_wr_data;
   logic                 tbl_rd_en;
   logic [AW-1:0]        tbl_rd_addr;
   logic [RUNTIME_W-1:0] tbl_rd_data;

   mfss_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   mfss_table #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   mfss_datapath #(
      .MAX_SLOTS        (MAX_SLOTS),
      .DEFAULT_SLICE_NS (DEFAULT_SLICE_NS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .flags       (flags),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .tbl_wr_en   (tbl_wr_en),
      .tbl_wr_addr (tbl_wr_addr),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data)
   );

endmodule

// File: hdl/mfss_table.sv
// slot runtime memory, one write port and one registered read port
module mfss_table
   import mfss_pkg::*;
#(
   parameter int MAX_SLOTS = 64,
   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [RUNTIME_W-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [RUNTIME_W-1:0] rd_data
);

   logic [RUNTIME_W-1:0] mem [MAX_SLOTS];
   logic [RUNTIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mfss_sequencer.sv
// step counter and program table that drive the scheduler datapath
module mfss_sequencer
   import mfss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  flags_type flags,
   output ctrl_type  ctrl
);

   pc_type pc_ff;
   pc_type pc_in;
   logic   taken;

   assign ctrl = PROGRAM[pc_ff];

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:        taken = 1'b0;
         C_ALWAYS:       taken = 1'b1;
         C_EMPTY:        taken = flags.empty;
         C_BEFORE_FRAME: taken = flags.before_frame;
         C_WALK_DONE:    taken = flags.walk_done;
         C_LAST_SLOT:    taken = flags.last_slot;
         C_DUE_AGAIN:    taken = flags.due_again;
         default:        taken = 1'b0;
      endcase
   end

   always_comb begin
      if (flags.stall) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = ctrl.target;
      end else begin
         pc_in = pc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= L_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// File: hdl/mfss_datapath.sv
// scheduler registers, shared saturating adder, handshakes and result register
module mfss_datapath
   import mfss_pkg::*;
#(
   parameter int MAX_SLOTS        = 64,
   parameter int DEFAULT_SLICE_NS = 10000000,
   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   output flags_type              flags,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   tbl_wr_en,
   output logic [AW-1:0]          tbl_wr_addr,
   output logic [RUNTIME_W-1:0]   tbl_wr_data,
   output logic                   tbl_rd_en,
   output logic [AW-1:0]          tbl_rd_addr,
   input  logic [RUNTIME_W-1:0]   tbl_rd_data
);

   logic [INDEX_W-1:0]   req_slot_index;
   logic [RUNTIME_W-1:0] req_slot_runtime;
   logic [TIME_W-1:0]    req_current_time;
   logic                 req_tasklet;
   logic                 req_accept;
   logic                 csr_accept;

   logic [RUNTIME_W-1:0] major_frame_ff, major_frame_in;
   logic [SLOT_W-1:0]    entry_count_ff, entry_count_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic                 tasklet_ff, tasklet_in;
   logic [TIME_W-1:0]    frame_start_ff, frame_start_in;
   logic [TIME_W-1:0]    switch_ff, switch_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_idle_ff, rsp_idle_in;
   logic [TIME_W-1:0]    rsp_slice_ff, rsp_slice_in;

   logic [SLOT_W-1:0]    n_eff;
   logic [SLOT_W:0]      slot_next;
   logic                 past_end;
   logic [TIME_W-1:0]    add_a, add_b, sum_val;
   logic                 load_rsp;

   assign req_slot_index   = req_tdata[5:0];
   assign req_slot_runtime = req_tdata[45:6];
   assign req_current_time = req_tdata[108:46];
   assign req_tasklet      = req_tdata[109];

   assign req_tready = (ctrl.op == OP_WAIT);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;

   assign n_eff     = (32'(entry_count_ff) > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : entry_count_ff;
   assign slot_next = {1'b0, slot_ff} + 8'd1;
   assign past_end  = (slot_ff >= n_eff);

   // shared adder operand select
   always_comb begin
      add_a = (ctrl.op == OP_ADD) ? switch_ff : now_ff;
      case (ctrl.op)
         OP_RESTART: add_b = TIME_W'(major_frame_ff);
         OP_EMPTY:   add_b = TIME_W'(DEFAULT_SLICE_NS);
         default:    add_b = TIME_W'(tbl_rd_data);
      endcase
   end

   assign sum_val = sat_add(add_a, add_b);

   assign load_rsp = (ctrl.op == OP_RESULT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      flags.empty        = (n_eff == '0);
      flags.before_frame = (now_ff < frame_start_ff);
      flags.walk_done    = (now_ff < switch_ff) || past_end;
      flags.last_slot    = (slot_next >= {1'b0, n_eff});
      flags.due_again    = (now_ff >= sum_val);
      flags.stall        = ((ctrl.op == OP_WAIT) && !(req_accept && req_tuser == MODE_DECIDE))
                           || ((ctrl.op == OP_RESULT) && !load_rsp);
   end

   assign tbl_wr_en   = req_accept && (req_tuser == MODE_WRITE)
                        && (32'(req_slot_index) < MAX_SLOTS);
   assign tbl_wr_addr = AW'(req_slot_index);
   assign tbl_wr_data = req_slot_runtime;
   assign tbl_rd_en   = (ctrl.op == OP_RESTART) || (ctrl.op == OP_ADVANCE);
   assign tbl_rd_addr = (ctrl.op == OP_RESTART) ? '0 : AW'(slot_next);

   always_comb begin
      major_frame_in = major_frame_ff;
      entry_count_in = entry_count_ff;
      if (csr_accept) begin
         case (csr_index)
            CSR_MAJOR_FRAME_LENGTH: major_frame_in = csr_data;
            CSR_ENTRY_COUNT:        entry_count_in = csr_data[SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      now_in         = now_ff;
      tasklet_in     = tasklet_ff;
      frame_start_in = frame_start_ff;
      switch_in      = switch_ff;
      slot_in        = slot_ff;
      if (req_accept && req_tuser == MODE_DECIDE) begin
         now_in     = req_current_time;
         tasklet_in = req_tasklet;
      end
      case (ctrl.op)
         OP_RESTART: begin
            slot_in        = '0;
            frame_start_in = sum_val;
         end
         OP_LOAD_FIRST: switch_in      = sum_val;
         OP_ADVANCE:    slot_in        = slot_next[SLOT_W-1:0];
         OP_ADD:        switch_in      = sum_val;
         OP_EMPTY:      frame_start_in = sum_val;
         OP_POST: begin
            if (past_end) begin
               switch_in = frame_start_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_slice_in = rsp_slice_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = past_end ? n_eff : slot_ff;
         rsp_idle_in  = past_end || tasklet_ff;
         rsp_slice_in = (switch_ff > now_ff) ? (switch_ff - now_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         major_frame_ff <= '0;
         entry_count_ff <= '0;
         frame_start_ff <= '0;
         switch_ff      <= '0;
         slot_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         major_frame_ff <= major_frame_in;
         entry_count_ff <= entry_count_in;
         frame_start_ff <= frame_start_in;
         switch_ff      <= switch_in;
         slot_ff        <= slot_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      tasklet_ff   <= tasklet_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_idle_ff  <= rsp_idle_in;
      rsp_slice_ff <= rsp_slice_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_idle_ff;
   assign rsp_tdata  = {2'b00, rsp_slice_ff, rsp_slot_ff};

   a_advance_steps_one: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_ADVANCE |=> slot_ff == SLOT_W'($past(slot_ff) + 7'd1))
      else $error("slot did not advance by one");

   a_first_slot_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_LOAD_FIRST |-> slot_ff == '0)
      else $error("frame restart did not select the first slot");

   a_idle_switch_at_frame: assert property (@(posedge clock) disable iff (reset)
      ctrl.op == OP_POST && past_end |=> switch_ff == frame_start_ff)
      else $error("switch time not moved to frame end past the last slot");

endmodule
